// ===== hw/rtl/x86enc_pkg.sv =====
// Package: request form codes and opcode constants for the instruction byte encoder.
package x86enc_pkg;

  // Instruction form requested by one input transaction
  typedef enum logic [2:0] {
    FormMovImm = 3'd0,
    FormMovReg = 3'd1,
    FormAddImm = 3'd2,
    FormPush   = 3'd3,
    FormPop    = 3'd4,
    FormRet    = 3'd5
  } form_e;

  // REX prefix bits
  localparam logic [7:0] RexBase = 8'h40;
  localparam logic [7:0] RexW    = 8'h08;
  localparam logic [7:0] RexR    = 8'h04;
  localparam logic [7:0] RexB    = 8'h01;

  // Opcodes
  localparam logic [7:0] OpMovImm = 8'hB8;
  localparam logic [7:0] OpMovReg = 8'h89;
  localparam logic [7:0] OpAddImm = 8'h81;
  localparam logic [7:0] OpPush   = 8'h50;
  localparam logic [7:0] OpPop    = 8'h58;
  localparam logic [7:0] OpRet    = 8'hC3;
  localparam logic [7:0] ModRmReg = 8'hC0;   // mod = 3, register direct

  // Instruction lengths in bytes
  localparam logic [3:0] LenMovImm = 4'd10;
  localparam logic [3:0] LenMovReg = 4'd3;
  localparam logic [3:0] LenAddImm = 4'd7;

  // First immediate byte position per form
  localparam logic [2:0] ImmStartMov = 3'd2;
  localparam logic [2:0] ImmStartAdd = 3'd3;

endpackage

// ===== hw/rtl/x86_64_instruction_byte_encoder.sv =====
// Top level: streams the machine-code bytes of one x86-64 instruction per request.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | req_type_i, dst_reg_i, src_reg_i, immediate_i
//  out     | output    | out_valid_o / out_stall_i | code_byte_o, byte_index_o, is_last_o
//
// One byte leaves per cycle from the output register while out_stall_i is low; an instruction
// has 1 to 10 bytes (mov imm64 10, add imm32 7, mov reg 3, push/pop 1-2, ret 1).
// Undefined form codes produce no bytes and free the request register without loading a byte.
// The next request is taken in the cycle that the last byte of the current one is loaded.
// A stall on the output holds the output register and, behind it, the request register.
// Reset clears only the valid flags.
module x86_64_instruction_byte_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [3:0]         dst_reg_i,
  input  logic [3:0]         src_reg_i,
  input  logic signed [63:0] immediate_i,
  // byte channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         code_byte_o,
  output logic [3:0]         byte_index_o,
  output logic               is_last_o
);

  // Request register
  logic        req_vld_q;
  logic [2:0]  form_q;
  logic [3:0]  dst_q;
  logic [3:0]  src_q;
  logic [63:0] imm_q;
  logic [3:0]  pos_q;

  // Output register
  logic        out_vld_q;
  logic [7:0]  byte_q;
  logic [3:0]  idx_q;
  logic        last_q;

  logic [3:0]  len;
  logic [3:0]  len_m1;
  logic [7:0]  byte_d;
  logic [2:0]  imm_sel;
  logic [7:0]  imm_byte;
  logic [7:0]  rex_b;
  logic [7:0]  rex_r;
  logic        adv;
  logic        load;
  logic        drop;
  logic        done;
  logic        accept;

  assign rex_b = dst_q[3] ? x86enc_pkg::RexB : 8'h00;
  assign rex_r = src_q[3] ? x86enc_pkg::RexR : 8'h00;

  // Instruction length
  always_comb begin
    case (form_q)
      x86enc_pkg::FormMovImm: len = x86enc_pkg::LenMovImm;
      x86enc_pkg::FormMovReg: len = x86enc_pkg::LenMovReg;
      x86enc_pkg::FormAddImm: len = x86enc_pkg::LenAddImm;
      x86enc_pkg::FormPush,
      x86enc_pkg::FormPop:    len = dst_q[3] ? 4'd2 : 4'd1;
      x86enc_pkg::FormRet:    len = 4'd1;
      default:                len = 4'd0;
    endcase
  end
  assign len_m1 = len - 4'd1;

  // Immediate byte select, least significant byte first
  assign imm_sel  = (form_q == x86enc_pkg::FormAddImm) ? pos_q[2:0] - x86enc_pkg::ImmStartAdd
                                                       : pos_q[2:0] - x86enc_pkg::ImmStartMov;
  assign imm_byte = imm_q[{imm_sel, 3'b000} +: 8];

  // Byte at the current position
  always_comb begin
    case (form_q)
      x86enc_pkg::FormMovImm: begin
        case (pos_q)
          4'd0:    byte_d = x86enc_pkg::RexBase | x86enc_pkg::RexW | rex_b;
          4'd1:    byte_d = x86enc_pkg::OpMovImm + {5'd0, dst_q[2:0]};
          default: byte_d = imm_byte;
        endcase
      end
      x86enc_pkg::FormMovReg: begin
        case (pos_q)
          4'd0:    byte_d = x86enc_pkg::RexBase | x86enc_pkg::RexW | rex_r | rex_b;
          4'd1:    byte_d = x86enc_pkg::OpMovReg;
          default: byte_d = x86enc_pkg::ModRmReg | {2'b00, src_q[2:0], dst_q[2:0]};
        endcase
      end
      x86enc_pkg::FormAddImm: begin
        case (pos_q)
          4'd0:    byte_d = x86enc_pkg::RexBase | x86enc_pkg::RexW | rex_b;
          4'd1:    byte_d = x86enc_pkg::OpAddImm;
          4'd2:    byte_d = x86enc_pkg::ModRmReg | {5'd0, dst_q[2:0]};
          default: byte_d = imm_byte;
        endcase
      end
      x86enc_pkg::FormPush,
      x86enc_pkg::FormPop: begin
        // extended registers get a REX.B prefix first
        if (dst_q[3] && pos_q == 4'd0) begin
          byte_d = x86enc_pkg::RexBase | x86enc_pkg::RexB;
        end else if (form_q == x86enc_pkg::FormPush) begin
          byte_d = x86enc_pkg::OpPush + {5'd0, dst_q[2:0]};
        end else begin
          byte_d = x86enc_pkg::OpPop + {5'd0, dst_q[2:0]};
        end
      end
      default: byte_d = x86enc_pkg::OpRet;
    endcase
  end

  // Handshake control
  assign adv        = !out_vld_q || !out_stall_i;
  assign load       = req_vld_q && (len != 4'd0) && adv;
  assign drop       = req_vld_q && (len == 4'd0);
  assign done       = drop || (load && pos_q == len_m1);
  assign in_stall_o = req_vld_q && !done;
  assign accept     = in_valid_i && !in_stall_o;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        req_vld_q <= 1'b1;
      end else if (done) begin
        req_vld_q <= 1'b0;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Request payload and byte position
  always_ff @(posedge clk_i) begin
    if (accept) begin
      form_q <= req_type_i;
      dst_q  <= dst_reg_i;
      src_q  <= src_reg_i;
      imm_q  <= immediate_i;
      pos_q  <= 4'd0;
    end else if (load) begin
      pos_q  <= pos_q + 4'd1;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      idx_q  <= pos_q;
      last_q <= (pos_q == len_m1);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign code_byte_o  = byte_q;
  assign byte_index_o = idx_q;
  assign is_last_o    = last_q;

endmodule
